// ----- design/aabb_pkg.sv -----
// aabb_pkg: shared constants, register index codes and saturation helpers
// for the box transform pipeline; no dependencies
`default_nettype none

package aabb_pkg;

  localparam int CoordW    = 32;  // signed Q16.16 center and corner width
  localparam int ExtW      = 31;  // unsigned Q15.16 size width
  localparam int CoefW     = 16;  // signed Q2.14 matrix entry
  localparam int FracShift = 14;  // product realignment Q18.30 -> Q16.16
  localparam int RowW      = 3 * CoefW;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = RowW;

  // product and sum widths
  localparam int PcW  = CoordW + CoefW - FracShift;      // 34, truncated center product
  localparam int PeW  = ExtW + 1 + CoefW - 1 - FracShift; // 33, truncated size product
  localparam int ScW  = PcW + 2;                         // 36, three products plus offset
  localparam int SeW  = PeW + 2;                         // 35, sum of three magnitudes
  localparam int CrnW = CoordW + 1;                      // 33, center plus or minus half

  typedef enum logic [CfgIdxW-1:0] {
    CfgRowX = 3'd0,
    CfgRowY = 3'd1,
    CfgRowZ = 3'd2,
    CfgOffX = 3'd3,
    CfgOffY = 3'd4,
    CfgOffZ = 3'd5
  } cfg_idx_e;

  // identity matrix at reset
  localparam logic [RowW-1:0] RowXRst = 48'h0000_0000_4000;
  localparam logic [RowW-1:0] RowYRst = 48'h0000_4000_0000;
  localparam logic [RowW-1:0] RowZRst = 48'h4000_0000_0000;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [ExtW-1:0]          extent_t;
  typedef logic signed [CoefW-1:0]  coef_t;

  function automatic coord_t sat_center(input logic signed [ScW-1:0] v);
    coord_t r;
    if (&v[ScW-1:CoordW-1] || ~|v[ScW-1:CoordW-1]) begin
      r = v[CoordW-1:0];
    end else if (v[ScW-1]) begin
      r = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      r = {1'b0, {(CoordW-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic extent_t sat_extent(input logic [SeW-1:0] v);
    extent_t r;
    if (|v[SeW-1:ExtW]) begin
      r = {ExtW{1'b1}};
    end else begin
      r = v[ExtW-1:0];
    end
    return r;
  endfunction

  function automatic coord_t sat_corner(input logic signed [CrnW-1:0] v);
    coord_t r;
    if (v[CrnW-1] == v[CrnW-2]) begin
      r = v[CoordW-1:0];
    end else if (v[CrnW-1]) begin
      r = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      r = {1'b0, {(CoordW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/aabb_affine_transform.sv -----
// aabb_affine_transform: top level of the box transform, four-stage pipeline
// depends on aabb_pkg for widths, register codes and saturation helpers
//
// one item (a box as center and size) is taken at each clock edge where
// start_i is high; busy_o stays low, so a new item can follow every cycle and
// the sustained rate is one item per clock. done_o marks the result for one
// cycle, after the input, product, sum and result registers; the receiver
// cannot stall, so each result must be taken then. stages: input register,
// the eighteen 32x16 multipliers (one set per item, fully pipelined), the
// three-way sums with saturation, and the corner add/subtract with
// saturation. the matrix rows and translation are written through cfg_we_i/
// cfg_idx_i/cfg_data_i; the user must do so only while no item is in flight
// (the block does not enforce this); writes to unused indexes are dropped
`default_nettype none

module aabb_affine_transform (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration write port
  input  wire logic                             cfg_we_i,
  input  wire logic [aabb_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [aabb_pkg::CfgDataW-1:0]    cfg_data_i,
  // item in
  input  wire logic                             start_i,
  output logic                                  busy_o,
  input  wire logic signed [aabb_pkg::CoordW-1:0] center_x_i,
  input  wire logic signed [aabb_pkg::CoordW-1:0] center_y_i,
  input  wire logic signed [aabb_pkg::CoordW-1:0] center_z_i,
  input  wire logic [aabb_pkg::ExtW-1:0]        extent_x_i,
  input  wire logic [aabb_pkg::ExtW-1:0]        extent_y_i,
  input  wire logic [aabb_pkg::ExtW-1:0]        extent_z_i,
  // result out
  output logic                                  done_o,
  output logic signed [aabb_pkg::CoordW-1:0]    new_center_x_o,
  output logic signed [aabb_pkg::CoordW-1:0]    new_center_y_o,
  output logic signed [aabb_pkg::CoordW-1:0]    new_center_z_o,
  output logic [aabb_pkg::ExtW-1:0]             new_extent_x_o,
  output logic [aabb_pkg::ExtW-1:0]             new_extent_y_o,
  output logic [aabb_pkg::ExtW-1:0]             new_extent_z_o,
  output logic signed [aabb_pkg::CoordW-1:0]    corner_lo_x_o,
  output logic signed [aabb_pkg::CoordW-1:0]    corner_lo_y_o,
  output logic signed [aabb_pkg::CoordW-1:0]    corner_lo_z_o,
  output logic signed [aabb_pkg::CoordW-1:0]    corner_hi_x_o,
  output logic signed [aabb_pkg::CoordW-1:0]    corner_hi_y_o,
  output logic signed [aabb_pkg::CoordW-1:0]    corner_hi_z_o
);

  import aabb_pkg::*;

  // ---------------------------------------------------------------------------
  // configuration registers
  // row_q[i] holds matrix row i, entry j at bits [16j +: 16]
  // ---------------------------------------------------------------------------
  logic [RowW-1:0] row_q [3];
  coord_t          off_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= RowXRst;
      row_q[1] <= RowYRst;
      row_q[2] <= RowZRst;
      off_q[0] <= '0;
      off_q[1] <= '0;
      off_q[2] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgRowX: row_q[0] <= cfg_data_i;
        CfgRowY: row_q[1] <= cfg_data_i;
        CfgRowZ: row_q[2] <= cfg_data_i;
        CfgOffX: off_q[0] <= cfg_data_i[CoordW-1:0];
        CfgOffY: off_q[1] <= cfg_data_i[CoordW-1:0];
        CfgOffZ: off_q[2] <= cfg_data_i[CoordW-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline valid bits: input, products, sums, result
  // ---------------------------------------------------------------------------
  logic in_vld_q, prod_vld_q, sum_vld_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
      sum_vld_q  <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      in_vld_q   <= start_i;
      prod_vld_q <= in_vld_q;
      sum_vld_q  <= prod_vld_q;
      done_q     <= sum_vld_q;
    end
  end

  // fully pipelined, never refuses an item
  assign busy_o = 1'b0;
  assign done_o = done_q;

  // ---------------------------------------------------------------------------
  // stage 0: input register (payload only, no reset needed)
  // ---------------------------------------------------------------------------
  coord_t  cin_q [3];
  extent_t ein_q [3];

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      cin_q[0] <= center_x_i;
      cin_q[1] <= center_y_i;
      cin_q[2] <= center_z_i;
      ein_q[0] <= extent_x_i;
      ein_q[1] <= extent_y_i;
      ein_q[2] <= extent_z_i;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: products, truncated toward minus infinity by dropping the low
  // FracShift bits (arithmetic shift). index [j][i]: output axis j, row i
  // ---------------------------------------------------------------------------
  logic signed [PcW-1:0] pc_d [3][3];
  logic signed [PeW-1:0] pe_d [3][3];
  logic signed [PcW-1:0] pc_q [3][3];
  logic signed [PeW-1:0] pe_q [3][3];

  always_comb begin
    coef_t                        m;
    logic signed [CoordW+CoefW-1:0] cprod;
    logic signed [CoordW+CoefW-1:0] eprod;
    coord_t                       es;
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        m     = signed'(row_q[i][CoefW*j +: CoefW]);
        es    = signed'({1'b0, ein_q[i]});
        cprod = cin_q[i] * m;
        eprod = es * m;
        pc_d[j][i] = signed'(cprod[CoordW+CoefW-1:FracShift]);
        // size product fits in one bit less than the center product
        pe_d[j][i] = signed'(eprod[CoordW+CoefW-2:FracShift]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pc_q <= pc_d;
    pe_q <= pe_d;
  end

  // ---------------------------------------------------------------------------
  // stage 2: center sum with translation, size sum of magnitudes; saturate
  // ---------------------------------------------------------------------------
  coord_t  nc_d [3];
  extent_t ne_d [3];
  coord_t  nc_q [3];
  extent_t ne_q [3];

  always_comb begin
    logic signed [ScW-1:0] sc;
    logic [SeW-1:0]        se;
    logic [PeW-1:0]        mag;
    for (int j = 0; j < 3; j++) begin
      sc = ScW'(off_q[j]);
      se = '0;
      for (int i = 0; i < 3; i++) begin
        sc  = sc + ScW'(pc_q[j][i]);
        // magnitude after truncation; the most negative value maps to 2^32
        mag = pe_q[j][i][PeW-1] ? (~pe_q[j][i] + 1'b1) : pe_q[j][i];
        se  = se + SeW'(mag);
      end
      nc_d[j] = sat_center(sc);
      ne_d[j] = sat_extent(se);
    end
  end

  always_ff @(posedge clk_i) begin
    nc_q <= nc_d;
    ne_q <= ne_d;
  end

  // ---------------------------------------------------------------------------
  // stage 3: corners from saturated center and half size, result register
  // ---------------------------------------------------------------------------
  coord_t  lo_d [3];
  coord_t  hi_d [3];
  coord_t  res_c_q  [3];
  extent_t res_e_q  [3];
  coord_t  res_lo_q [3];
  coord_t  res_hi_q [3];

  always_comb begin
    logic signed [CrnW-1:0] c_ext;
    logic signed [CrnW-1:0] half;
    for (int j = 0; j < 3; j++) begin
      c_ext   = CrnW'(nc_q[j]);
      half    = signed'(CrnW'(ne_q[j][ExtW-1:1]));
      lo_d[j] = sat_corner(c_ext - half);
      hi_d[j] = sat_corner(c_ext + half);
    end
  end

  always_ff @(posedge clk_i) begin
    res_c_q  <= nc_q;
    res_e_q  <= ne_q;
    res_lo_q <= lo_d;
    res_hi_q <= hi_d;
  end

  assign new_center_x_o = res_c_q[0];
  assign new_center_y_o = res_c_q[1];
  assign new_center_z_o = res_c_q[2];
  assign new_extent_x_o = res_e_q[0];
  assign new_extent_y_o = res_e_q[1];
  assign new_extent_z_o = res_e_q[2];
  assign corner_lo_x_o  = res_lo_q[0];
  assign corner_lo_y_o  = res_lo_q[1];
  assign corner_lo_z_o  = res_lo_q[2];
  assign corner_hi_x_o  = res_hi_q[0];
  assign corner_hi_y_o  = res_hi_q[1];
  assign corner_hi_z_o  = res_hi_q[2];

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
`ifndef SYNTHESIS
  // every accepted item comes out through the product, sum and result registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == $past(in_vld_q, 3))
    else $error("result strobe does not follow the accepted item");

  // corners bracket the center on every axis
  a_order_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (corner_lo_x_o <= new_center_x_o) && (new_center_x_o <= corner_hi_x_o))
    else $error("x corners do not bracket the center");

  a_order_yz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (corner_lo_y_o <= new_center_y_o) && (new_center_y_o <= corner_hi_y_o) &&
               (corner_lo_z_o <= new_center_z_o) && (new_center_z_o <= corner_hi_z_o))
    else $error("y or z corners do not bracket the center");
`endif

endmodule

`default_nettype wire
